// ===== sv/binary_morphology_3x3_unit_defines.svh =====
// Assertion macros used by the checker module of the morphology unit.
// Depends on nothing; included by the checker module by bare file name.
`ifndef BINARY_MORPHOLOGY_3X3_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BM_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define BM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== sv/bmorph_pkg.sv =====
// Package for the 3x3 binary morphology unit: codes, defaults and helpers.
// Used by the row store and the top level; depends on nothing.
`timescale 1ns / 1ps

package bmorph_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Field widths fixed by the interface.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int WINDOW_W    = 9;

   // Each row store entry holds the pixel from two rows back (bit 0)
   // and the pixel from one row back (bit 1).
   localparam int LINE_W = 2;

   localparam logic [CSR_DATA_W-1:0] IMAGE_DIM_RESET = 11'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OPERATION    = 2'd0,
      REG_MASK_SHAPE   = 2'd1,
      REG_IMAGE_WIDTH  = 2'd2,
      REG_IMAGE_HEIGHT = 2'd3
   } csr_reg_type;

   localparam logic OP_DILATE    = 1'b0;
   localparam logic OP_ERODE     = 1'b1;
   localparam logic MASK_SQUARE  = 1'b0;
   localparam logic MASK_CROSS   = 1'b1;
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // Clamp a written frame dimension to [1, top].
   function automatic int sat_dim(logic [CSR_DATA_W-1:0] value, int top);
      int v;
      v = int'(value);
      if (v < 1) begin
         return 1;
      end
      if (v > top) begin
         return top;
      end
      return v;
   endfunction

endpackage

// ===== sv/bmorph_line_ram.sv =====
// Row store memory for the morphology unit: one write and one registered read port.
// A read of the address being written in the same cycle returns the new data.
// Depends on bmorph_pkg for the entry width.
`timescale 1ns / 1ps

module bmorph_line_ram #(
   parameter int DEPTH = bmorph_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [bmorph_pkg::LINE_W-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [bmorph_pkg::LINE_W-1:0]     rd_data
);

   logic [bmorph_pkg::LINE_W-1:0] mem [DEPTH];
   logic [bmorph_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/binary_morphology_3x3_unit.sv =====
// 3x3 binary dilation / erosion on a raster pixel stream.
// A result leaves through a registered output in the cycle after the item that
// completes its window, i.e. one row plus one pixel behind the input.
// One item per cycle while req_ready is high; the row store read is prefetched.
// Synchronous reset clears configuration to its defaults, the counters, the window
// and the output valid; row store contents are left as they are.
`timescale 1ns / 1ps

module binary_morphology_3x3_unit #(
   parameter int MAX_WIDTH  = bmorph_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmorph_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic                                 req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_pixel_out,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmorph_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bmorph_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int FW = $clog2(MAX_WIDTH + 2);
   localparam int NW = bmorph_pkg::WINDOW_W;

   localparam logic [WW-1:0] WIDTH_RESET =
      WW'(bmorph_pkg::sat_dim(bmorph_pkg::IMAGE_DIM_RESET, MAX_WIDTH));
   localparam logic [HW-1:0] HEIGHT_RESET =
      HW'(bmorph_pkg::sat_dim(bmorph_pkg::IMAGE_DIM_RESET, MAX_HEIGHT));

   // Configuration.
   logic          operation_ff, operation_in;
   logic          mask_shape_ff, mask_shape_in;
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   // Frame state.
   logic [NW-1:0] window_ff, window_in;
   logic [AW-1:0] in_col_ff, in_col_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic [FW-1:0] fill_ff, fill_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pixel_ff, rsp_pixel_in;
   logic rsp_frame_end_ff, rsp_frame_end_in;

   logic                          accept, in_frame, drop, step, pixel_bit;
   logic                          csr_we, geom_write;
   logic [bmorph_pkg::LINE_W-1:0] line_rd, line_wr;
   logic [AW-1:0]                 line_rd_addr;
   logic [NW-1:0]                 window_next;
   logic                          col_wrap, emit, out_wrap, last, restart;
   logic [AW-1:0]                 in_col_step, out_col_step;
   logic [HW-1:0]                 in_row_step, out_row_step;
   logic                          left_ok, right_ok, top_ok, bottom_ok;
   logic                          any_black, any_white, result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign csr_we    = csr_valid && csr_ready;

   // A flush while the frame's input is still coming in is taken and ignored;
   // once the input is complete every item pushes a blank pixel.
   assign in_frame  = (in_row_ff < height_ff);
   assign drop      = in_frame && (req_action == bmorph_pkg::ACTION_FLUSH);
   assign step      = accept && !drop;
   assign pixel_bit = in_frame ? req_pixel_in : 1'b0;

   assign line_wr     = {pixel_bit, line_rd[1]};
   assign window_next = {pixel_bit, line_rd[1], line_rd[0], window_ff[NW-1:3]};

   assign col_wrap    = ((WW + 1)'(in_col_ff) + 1'b1) >= (WW + 1)'(width_ff);
   assign in_col_step = col_wrap ? '0 : in_col_ff + 1'b1;
   assign in_row_step = (col_wrap && in_frame) ? in_row_ff + 1'b1 : in_row_ff;

   // Results start once one row plus two pixels have gone in.
   assign emit = fill_ff >= (FW'(width_ff) + 1'b1);

   assign left_ok   = (out_col_ff != '0);
   assign right_ok  = ((WW + 1)'(out_col_ff) + 1'b1) < (WW + 1)'(width_ff);
   assign top_ok    = (out_row_ff != '0);
   assign bottom_ok = ((HW + 1)'(out_row_ff) + 1'b1) < (HW + 1)'(height_ff);

   always_comb begin
      logic [2:0] col_ok;
      logic [2:0] row_ok;
      logic       use_bit;
      col_ok    = {right_ok, 1'b1, left_ok};
      row_ok    = {bottom_ok, 1'b1, top_ok};
      any_black = 1'b0;
      any_white = 1'b0;
      for (int cs = 0; cs < 3; cs++) begin
         for (int rs = 0; rs < 3; rs++) begin
            use_bit = col_ok[cs] && row_ok[rs] &&
                      !((mask_shape_ff == bmorph_pkg::MASK_CROSS) && (cs != 1) && (rs != 1));
            if (use_bit) begin
               if (window_next[3 * cs + rs]) begin
                  any_black = 1'b1;
               end else begin
                  any_white = 1'b1;
               end
            end
         end
      end
   end

   assign result = (operation_ff == bmorph_pkg::OP_DILATE) ? any_black : !any_white;

   assign out_wrap     = ((WW + 1)'(out_col_ff) + 1'b1) >= (WW + 1)'(width_ff);
   assign out_col_step = out_wrap ? '0 : out_col_ff + 1'b1;
   assign out_row_step = out_wrap ? out_row_ff + 1'b1 : out_row_ff;
   assign last         = (out_row_step >= height_ff);
   assign restart      = step && emit && last;

   assign geom_write = csr_we && ((csr_index == bmorph_pkg::REG_IMAGE_WIDTH) ||
                                  (csr_index == bmorph_pkg::REG_IMAGE_HEIGHT));

   always_comb begin
      operation_in  = operation_ff;
      mask_shape_in = mask_shape_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (csr_we) begin
         case (csr_index)
            bmorph_pkg::REG_OPERATION: begin
               operation_in = csr_wdata[0];
            end
            bmorph_pkg::REG_MASK_SHAPE: begin
               mask_shape_in = csr_wdata[0];
            end
            bmorph_pkg::REG_IMAGE_WIDTH: begin
               width_in = WW'(bmorph_pkg::sat_dim(csr_wdata, MAX_WIDTH));
            end
            bmorph_pkg::REG_IMAGE_HEIGHT: begin
               height_in = HW'(bmorph_pkg::sat_dim(csr_wdata, MAX_HEIGHT));
            end
            default: begin
               operation_in = operation_ff;
            end
         endcase
      end
   end

   always_comb begin
      window_in  = window_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      fill_in    = fill_ff;
      if (step) begin
         window_in = window_next;
         in_col_in = in_col_step;
         in_row_in = in_row_step;
         if (emit) begin
            out_col_in = out_col_step;
            out_row_in = out_row_step;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (restart || geom_write) begin
         window_in  = '0;
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         fill_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in     = rsp_pixel_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (step && emit) begin
         rsp_valid_in     = 1'b1;
         rsp_pixel_in     = result;
         rsp_frame_end_in = last;
      end
   end

   // The store is read one item ahead: the address is the column that the
   // next item will see.
   assign line_rd_addr = reset ? '0 : in_col_in;

   bmorph_line_ram #(
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (in_col_ff),
      .wr_data (line_wr),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff  <= bmorph_pkg::OP_DILATE;
         mask_shape_ff <= bmorph_pkg::MASK_SQUARE;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         window_ff     <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         operation_ff  <= operation_in;
         mask_shape_ff <= mask_shape_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         window_ff     <= window_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff     <= rsp_pixel_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

// ===== sv/bmorph_checker.sv =====
// Port-level checks for the morphology unit, attached to the top level by bind.
// Depends on the assertion macros in binary_morphology_3x3_unit_defines.svh.
`timescale 1ns / 1ps
`include "binary_morphology_3x3_unit_defines.svh"

module bmorph_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pixel_out,
   input logic rsp_frame_end
);

   // A waiting result holds its value until it is taken.
   `BM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_frame_end))

   // With the output register empty the unit always takes the next item.
   `BM_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A fresh result only follows an accepted item.
   `BM_ASSERT_IMPLY(a_rsp_after_item, clock, reset, rsp_valid && !$past(rsp_valid), $past(req_valid && req_ready))

   // A new result replaces a taken one only if an item was accepted meanwhile.
   `BM_ASSERT_NEXT(a_no_phantom, clock, reset, rsp_valid && rsp_ready && !(req_valid && req_ready), !rsp_valid)

endmodule

bind binary_morphology_3x3_unit bmorph_checker u_bmorph_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_frame_end (rsp_frame_end)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for binary_morphology_3x3_unit: a short directed table, then
// random frames of random geometry, operation and mask checked against a predictor.
// Depends on bmorph_pkg and the unit itself.
`timescale 1ns / 1ps

module testbench;

   localparam int CSR_INDEX_W = bmorph_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = bmorph_pkg::CSR_DATA_W;
   localparam logic [CSR_DATA_W-1:0] IMAGE_DIM_RESET = bmorph_pkg::IMAGE_DIM_RESET;

   localparam bmorph_pkg::csr_reg_type REG_OPERATION    = bmorph_pkg::REG_OPERATION;
   localparam bmorph_pkg::csr_reg_type REG_MASK_SHAPE   = bmorph_pkg::REG_MASK_SHAPE;
   localparam bmorph_pkg::csr_reg_type REG_IMAGE_WIDTH  = bmorph_pkg::REG_IMAGE_WIDTH;
   localparam bmorph_pkg::csr_reg_type REG_IMAGE_HEIGHT = bmorph_pkg::REG_IMAGE_HEIGHT;

   localparam logic OP_DILATE    = bmorph_pkg::OP_DILATE;
   localparam logic OP_ERODE     = bmorph_pkg::OP_ERODE;
   localparam logic MASK_SQUARE  = bmorph_pkg::MASK_SQUARE;
   localparam logic MASK_CROSS   = bmorph_pkg::MASK_CROSS;
   localparam logic ACTION_PIXEL = bmorph_pkg::ACTION_PIXEL;
   localparam logic ACTION_FLUSH = bmorph_pkg::ACTION_FLUSH;

   localparam int ROW_LIMIT = bmorph_pkg::DEF_MAX_WIDTH;
   localparam int COL_LIMIT = bmorph_pkg::DEF_MAX_HEIGHT;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_PIXEL_GOAL = 800;
   localparam int EDGE_PHASE_ITEMS = 150;
   localparam int DIRECTED_ROWS = 31;

   typedef struct packed {
      logic pixel_out;
      logic frame_end;
   } morph_result_type;

   typedef struct packed {
      logic                    write_csr;
      bmorph_pkg::csr_reg_type index;
      logic [CSR_DATA_W-1:0]   value;
      logic                    action;
      logic                    pixel;
      logic                    known;
      logic                    has_out;
      logic                    out_pixel;
      logic                    out_end;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_action;
   logic                   req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_pixel_out;
   logic                   rsp_frame_end;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predictor state: configuration, two stored rows and the 3x3 neighborhood.
   logic       cfg_erode;
   logic       cfg_cross;
   int         frame_w;
   int         frame_h;
   logic       two_rows_back [ROW_LIMIT];
   logic       one_row_back [ROW_LIMIT];
   logic [8:0] neighborhood;
   int         feed_x;
   int         feed_y;
   int         emit_x;
   int         emit_y;
   int         frames_predicted = 0;

   morph_result_type pending_pixels [$];
   int               mismatches = 0;
   int               random_pixels_sent = 0;
   int               burst_left = 0;
   int unsigned      stall_count = 0;
   int               idle_cycles = 0;

   // Columns: csr write, register, value, action, pixel, result known,
   // result present, pixel_out, frame_end.
   directed_row_type directed_steps [DIRECTED_ROWS] = '{
      '{1'b1, REG_IMAGE_WIDTH, 11'd2, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, REG_IMAGE_HEIGHT, 11'd2, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      // A flush before the frame is complete does nothing.
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{1'b1, REG_OPERATION, CSR_DATA_W'(OP_ERODE), ACTION_PIXEL, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0},
      '{1'b1, REG_MASK_SHAPE, CSR_DATA_W'(MASK_CROSS), ACTION_PIXEL, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      // Pixels past the end of the frame input are dropped and drain like flushes.
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      // Zero geometry counts as a single pixel.
      '{1'b1, REG_IMAGE_WIDTH, 11'd0, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, REG_IMAGE_HEIGHT, 11'd0, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_FLUSH, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
      '{1'b1, REG_OPERATION, CSR_DATA_W'(OP_DILATE), ACTION_PIXEL, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0},
      '{1'b1, REG_MASK_SHAPE, CSR_DATA_W'(MASK_SQUARE), ACTION_PIXEL, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0},
      '{1'b1, REG_IMAGE_WIDTH, 11'd3, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, REG_IMAGE_HEIGHT, 11'd3, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, REG_OPERATION, 11'd0, ACTION_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      // Rewriting the width in the middle of a frame starts the frame over.
      '{1'b1, REG_IMAGE_WIDTH, 11'd3, ACTION_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   binary_morphology_3x3_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      if (mismatches < 20) begin
         $display("[%0t] ERROR: %0s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic void begin_new_frame();
      feed_x = 0;
      feed_y = 0;
      emit_x = 0;
      emit_y = 0;
      neighborhood = '0;
   endfunction

   function automatic void apply_config(input bmorph_pkg::csr_reg_type index,
                                        input logic [CSR_DATA_W-1:0] v);
      case (index)
         REG_OPERATION: begin
            cfg_erode = v[0];
         end
         REG_MASK_SHAPE: begin
            cfg_cross = v[0];
         end
         REG_IMAGE_WIDTH: begin
            frame_w = (v == 0) ? 1 : ((int'(v) > ROW_LIMIT) ? ROW_LIMIT : int'(v));
            begin_new_frame();
         end
         default: begin
            frame_h = (v == 0) ? 1 : ((int'(v) > COL_LIMIT) ? COL_LIMIT : int'(v));
            begin_new_frame();
         end
      endcase
   endfunction

   // Advances the morphology state by one item; returns 1 when an output pixel leaves.
   function automatic logic morph_predict(input logic act, input logic pix,
                                          output morph_result_type res);
      int         x;
      int         seen;
      logic       older;
      logic       newer;
      logic       saw_black;
      logic       saw_white;
      logic [2:0] column;
      res = '0;
      if (feed_y < frame_h) begin
         if (act == ACTION_FLUSH) begin
            return 1'b0;
         end
      end else begin
         pix = 1'b0;
      end
      x = feed_x;
      older = two_rows_back[x];
      newer = one_row_back[x];
      two_rows_back[x] = newer;
      one_row_back[x] = pix;
      column = {pix, newer, older};
      neighborhood = {column, neighborhood[8:3]};
      feed_x++;
      if (feed_x >= frame_w) begin
         feed_x = 0;
         feed_y++;
      end
      seen = feed_y * frame_w + feed_x;
      if (seen < frame_w + 2) begin
         return 1'b0;
      end
      saw_black = 1'b0;
      saw_white = 1'b0;
      // Column slot 0 is the left neighbor, row slot 0 the row above.
      for (int cs = 0; cs < 3; cs++) begin
         for (int rs = 0; rs < 3; rs++) begin
            if (cs == 0 && emit_x < 1) continue;
            if (cs == 2 && emit_x + 1 >= frame_w) continue;
            if (rs == 0 && emit_y < 1) continue;
            if (rs == 2 && emit_y + 1 >= frame_h) continue;
            if (cfg_cross == MASK_CROSS && cs != 1 && rs != 1) continue;
            if (neighborhood[3 * cs + rs]) begin
               saw_black = 1'b1;
            end else begin
               saw_white = 1'b1;
            end
         end
      end
      res.pixel_out = (cfg_erode == OP_ERODE) ? !saw_white : saw_black;
      emit_x++;
      if (emit_x >= frame_w) begin
         emit_x = 0;
         emit_y++;
      end
      res.frame_end = (emit_y >= frame_h);
      if (res.frame_end) begin
         frames_predicted++;
         begin_new_frame();
      end
      return 1'b1;
   endfunction

   // Sends one item in bursts; known rows supply their own expected result.
   task automatic send_item(input logic act, input logic pix, input logic known,
                            input logic k_has, input logic k_pixel, input logic k_end);
      morph_result_type res;
      logic             has;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel_in <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has = morph_predict(act, pix, res);
      if (known) begin
         if (k_has) begin
            pending_pixels.push_back('{k_pixel, k_end});
         end
      end else if (has) begin
         pending_pixels.push_back(res);
      end
   endtask

   // Lowers valid and holds off until every expected item has come back.
   task automatic wait_results_done(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input bmorph_pkg::csr_reg_type index,
                            input logic [CSR_DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_config(index, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_dim(input int top);
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end
      return CSR_DATA_W'((r < 7) ? $urandom_range(1, 5) : $urandom_range(6, top));
   endfunction

   // One configuration setting followed by whole frames of random pixels, possibly
   // cut short so that the next setting lands in the middle of a frame. A positive
   // item cap bounds the number of items the phase sends.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] w_val, input logic [CSR_DATA_W-1:0] h_val,
                            input bit set_geom, input int frame_goal, input bit cut_short,
                            input bit pause, input int item_cap);
      int   density;
      int   budget;
      int   pause_at;
      int   start_frames;
      logic act;
      logic pix;
      bit   counts;
      wait_results_done(SETTLE_CYCLES);
      write_csr(REG_OPERATION, CSR_DATA_W'($urandom_range(1) ? OP_ERODE : OP_DILATE));
      write_csr(REG_MASK_SHAPE, CSR_DATA_W'($urandom_range(1) ? MASK_CROSS : MASK_SQUARE));
      if (set_geom) begin
         write_csr(REG_IMAGE_WIDTH, w_val);
         write_csr(REG_IMAGE_HEIGHT, h_val);
      end
      case ($urandom_range(3))
         0: density = 8;
         1: density = 92;
         default: density = $urandom_range(100);
      endcase
      budget = frame_goal * (frame_w * frame_h + frame_w + 2) * 9 / 8 + 4;
      if (cut_short) begin
         budget = $urandom_range(1, budget / 2 + 1);
      end
      if (item_cap > 0 && budget > item_cap) begin
         budget = item_cap;
      end
      pause_at = pause ? $urandom_range(budget - 1) : -1;
      start_frames = frames_predicted;
      for (int n = 0; n < budget && frames_predicted - start_frames < frame_goal; n++) begin
         if (n == pause_at) begin
            wait_results_done(0);
         end
         if (feed_y < frame_h) begin
            if ($urandom_range(24) == 0) begin
               act = ACTION_FLUSH;
               pix = 1'($urandom_range(1));
               counts = 1'b0;
            end else begin
               act = ACTION_PIXEL;
               pix = ($urandom_range(99) < density);
               counts = 1'b1;
            end
         end else begin
            act = ($urandom_range(4) == 0) ? ACTION_PIXEL : ACTION_FLUSH;
            pix = 1'($urandom_range(1));
            counts = 1'b1;
         end
         send_item(act, pix, 1'b0, 1'b0, 1'b0, 1'b0);
         if (counts) begin
            random_pixels_sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      morph_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report($sformatf("result item with nothing expected (pixel_out %b frame_end %b)",
                             rsp_pixel_out, rsp_frame_end));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel_out) begin
               report($sformatf("pixel_out %b, expected %b", rsp_pixel_out, want.pixel_out));
            end
            if (rsp_frame_end !== want.frame_end) begin
               report($sformatf("frame_end %b, expected %b", rsp_frame_end, want.frame_end));
            end
         end
      end
   end

   // The receiver alternates between always ready, random stalls and a fixed duty cycle.
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      case (stall_count[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(3) != 0);
         2'd2: rsp_ready <= (stall_count[3:0] < 4'd11);
         default: rsp_ready <= 1'($urandom_range(1));
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase_no;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACTION_PIXEL;
      req_pixel_in <= 1'b0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_OPERATION;
      csr_wdata <= '0;
      cfg_erode = OP_DILATE;
      cfg_cross = MASK_SQUARE;
      frame_w = int'(IMAGE_DIM_RESET);
      frame_h = int'(IMAGE_DIM_RESET);
      for (int i = 0; i < ROW_LIMIT; i++) begin
         two_rows_back[i] = 1'b0;
         one_row_back[i] = 1'b0;
      end
      begin_new_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].write_csr) begin
            wait_results_done(SETTLE_CYCLES);
            write_csr(directed_steps[i].index, directed_steps[i].value);
         end else begin
            send_item(directed_steps[i].action, directed_steps[i].pixel, directed_steps[i].known,
                      directed_steps[i].has_out, directed_steps[i].out_pixel,
                      directed_steps[i].out_end);
         end
      end

      // Largest geometry in each direction, with the other dimension at one pixel;
      // only the first part of each frame is sent.
      run_phase(11'd2047, 11'd1, 1'b1, 1, 1'b0, 1'b0, EDGE_PHASE_ITEMS);
      run_phase(11'd1, 11'd2047, 1'b1, 1, 1'b0, 1'b0, EDGE_PHASE_ITEMS);

      // The first random phase always leaves the large geometry behind.
      phase_no = 0;
      while (random_pixels_sent < RANDOM_PIXEL_GOAL) begin
         run_phase(pick_dim(20), pick_dim(12), phase_no == 0 || $urandom_range(3) != 0,
                   $urandom_range(1, 3), $urandom_range(4) == 0,
                   phase_no == 0 || $urandom_range(3) == 0,
                   RANDOM_PIXEL_GOAL + 40 - random_pixels_sent);
         phase_no++;
      end

      wait_results_done(20);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
